### rtl/core/b64e_pkg.sv
// Shared types, constants and the character lookup for the Base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

    // Phase of the next byte inside its three-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // One classified input byte: up to four characters to send
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [3:0]      pad;       // slot carries '=' instead of a sextet
        logic [1:0]      last_idx;  // index of the final slot used
        logic            last;      // byte ended the message
    } b64e_entry_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] s, input logic url);
        logic [6:0] c;
        c = 7'h00;
        if (s < 6'd26)
            c = 7'd65 + {1'b0, s};
        else if (s < 6'd52)
            c = 7'd71 + {1'b0, s};
        else if (s < 6'd62)
            c = {1'b0, s} - 7'd4;
        else if (s == 6'd62)
            c = url ? 7'h2D : 7'h2B;
        else
            c = url ? 7'h5F : 7'h2F;
        return c;
    endfunction

endpackage

### rtl/core/b64e_front.sv
// Front end: tracks group phase and carry bits, turns each byte into a queue entry.
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        url_mode,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output b64e_entry_t entry
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       pad;

    assign pad = ~url_mode;

    always_comb
    begin
        entry          = '0;
        entry.last     = last_byte;
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        case (phase_reg)
            PHASE_1:
            begin
                entry.sextet[0] = {carry_reg[1:0], data_byte[7:4]};
                entry.sextet[1] = {data_byte[3:0], 2'b00};
                entry.pad[2]    = 1'b1;
                entry.last_idx  = last_byte ? (pad ? 2'd2 : 2'd1) : 2'd0;
                carry_next      = data_byte[3:0];
                phase_next      = PHASE_2;
            end
            PHASE_2:
            begin
                entry.sextet[0] = {carry_reg, data_byte[7:6]};
                entry.sextet[1] = data_byte[5:0];
                entry.last_idx  = 2'd1;
                carry_next      = 4'd0;
                phase_next      = PHASE_0;
            end
            default:
            begin
                // phase 0, and the unused code 3 behaves the same
                entry.sextet[0] = data_byte[7:2];
                entry.sextet[1] = {data_byte[1:0], 4'b0000};
                entry.pad[2]    = 1'b1;
                entry.pad[3]    = 1'b1;
                entry.last_idx  = last_byte ? (pad ? 2'd3 : 2'd1) : 2'd0;
                carry_next      = {2'b00, data_byte[1:0]};
                phase_next      = PHASE_1;
            end
        endcase
        if (last_byte)
        begin
            phase_next = PHASE_0;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            carry_reg <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

### rtl/core/b64e_queue.sv
// Short FIFO of classified entries between front and back ends.
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64e_entry_t push_entry,
    input  logic        pop,
    output b64e_entry_t head,
    output logic        empty,
    output logic        full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    b64e_entry_t   mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/core/b64e_back.sv
// Back end: walks the slots of the head entry, one character word per cycle while out_stall is low.
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        url_mode,
    input  b64e_entry_t head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        run_last,
    output logic        message_end
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [6:0] char_reg;
    logic       run_last_reg;
    logic       end_reg;
    logic       load;
    logic       final_slot;

    // output register frees up when empty or being taken
    assign load       = !empty && (!valid_reg || !out_stall);
    assign final_slot = (idx_reg == head.last_idx);
    assign pop        = load && final_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= final_slot ? 2'd0 : idx_reg + 2'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg     <= head.pad[idx_reg] ? PAD_CHAR
                                              : sextet_char(head.sextet[idx_reg], url_mode);
            run_last_reg <= final_slot;
            end_reg      <= final_slot && head.last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign run_last    = run_last_reg;
    assign message_end = end_reg;

endmodule

### rtl/core/base64_encoder_top.sv
// Top level of the streaming Base64 encoder.
`timescale 1ns / 1ps

// Streaming Base64 encoder (standard or URL-safe alphabet).
// Input channel: in_valid / in_stall carries one raw byte word (data_byte)
// with last_byte set on the final byte of a message. A word is taken on a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carries one character word
// (out_char) with run_last on the last character caused by an input byte
// and message_end on the final character of the message.
// Config: cfg_valid / cfg_ready writes url_mode from cfg_data; cfg_ready is
// always high. Write it only while no message is in flight.
// A taken byte is written into the entry queue; its first character is then loaded into the output register.
// Throughput: one character per cycle while out_stall is low; a byte emits one or
// two characters (up to four on the final byte), so the sustained rate is bound
// by the single output register.
// The input side keeps accepting while the output stalls until the entry
// queue (QUEUE_DEPTH bytes) fills, then in_stall rises.
// Reset clears the group phase, carry bits, queue and url_mode (standard).

module base64_encoder_top
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_char,
    output logic       run_last,
    output logic       message_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic        url_mode_reg;
    logic        take;
    logic        full;
    logic        empty;
    logic        pop;
    b64e_entry_t entry;
    b64e_entry_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign take      = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            url_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            url_mode_reg <= cfg_data;
    end

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .url_mode  (url_mode_reg),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .entry     (entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .url_mode    (url_mode_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end)
    );

endmodule

### tb/base64_encoder_top_test.sv
// Self-checking testbench for the streaming Base64 encoder top level.
`timescale 1ns / 1ps

module base64_encoder_top_test;
    import b64e_pkg::*;

    localparam int RANDOM_BYTES = 235;

    localparam bit [8*64-1:0] STD_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam bit [8*64-1:0] URL_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef enum bit { ROW_BYTE, ROW_MODE } row_kind_t;

    // One directed row; n_typed > 0 means the characters are spelled out in typed_chars
    typedef struct {
        row_kind_t kind;
        bit [7:0]  data;
        bit        last;
        int        n_typed;
        bit [31:0] typed_chars;
    } stim_row_t;

    typedef struct {
        bit [6:0] ch;
        bit       byte_end;
        bit       msg_end;
    } b64_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    // predictor state
    bit         url_sel = 1'b0;
    bit [1:0]   grp_pos = PHASE_0;
    bit [3:0]   leftover = 4'h0;

    b64_char_t  pending_chars[$];
    stim_row_t  dir_rows[$];
    b64_char_t  got_want;
    bit         no_gaps = 1'b0;
    int         stall_left = 0;
    int         stall_len;
    int         errors = 0;
    int         bytes_sent = 0;
    int         msgs_sent = 0;
    int         chars_checked = 0;
    int         mode_writes = 0;

    base64_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic bit [6:0] b64_char(input bit [5:0] s);
        if (url_sel)
            return URL_ALPHA[8*(63-s) +: 7];
        return STD_ALPHA[8*(63-s) +: 7];
    endfunction

    // Advances the group state by one byte and returns the characters it completes
    function automatic int encode_byte(input bit [7:0] d, input bit l,
                                       output bit [3:0][6:0] ch);
        int n;
        n = 0;
        ch = '0;
        case (grp_pos)
            PHASE_1:
            begin
                ch[n++] = b64_char({leftover[1:0], d[7:4]});
                leftover = d[3:0];
                grp_pos = PHASE_2;
                if (l)
                begin
                    ch[n++] = b64_char({leftover, 2'b00});
                    if (!url_sel)
                        ch[n++] = PAD_CHAR;
                end
            end
            PHASE_2:
            begin
                ch[n++] = b64_char({leftover, d[7:6]});
                ch[n++] = b64_char(d[5:0]);
                leftover = 4'h0;
                grp_pos = PHASE_0;
            end
            default:
            begin
                ch[n++] = b64_char(d[7:2]);
                leftover = {2'b00, d[1:0]};
                grp_pos = PHASE_1;
                if (l)
                begin
                    ch[n++] = b64_char({d[1:0], 4'h0});
                    if (!url_sel)
                    begin
                        ch[n++] = PAD_CHAR;
                        ch[n++] = PAD_CHAR;
                    end
                end
            end
        endcase
        if (l)
        begin
            grp_pos = PHASE_0;
            leftover = 4'h0;
        end
        return n;
    endfunction

    task automatic add_row(input row_kind_t kind, input bit [7:0] d, input bit l,
                           input int n, input bit [31:0] txt);
        stim_row_t row;
        row.kind = kind;
        row.data = d;
        row.last = l;
        row.n_typed = n;
        row.typed_chars = txt;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic send_byte(input bit [7:0] d, input bit l, input int n_typed,
                             input bit [31:0] txt);
        bit [3:0][6:0] ch;
        b64_char_t     c;
        int            n;
        int            gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do @(posedge clk); while (in_stall);
        n = encode_byte(d, l, ch);
        if (n_typed > 0)
        begin
            n = n_typed;
            for (int i = 0; i < n_typed; i++)
                ch[i] = txt[8*(n_typed-1-i) +: 7];
        end
        for (int i = 0; i < n; i++)
        begin
            c.ch = ch[i];
            c.byte_end = (i == n - 1);
            c.msg_end = l && (i == n - 1);
            pending_chars.insert(pending_chars.size(), c);
        end
        bytes_sent++;
        if (l)
            msgs_sent++;
    endtask

    // Sender holds off until every predicted character has gone out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
    endtask

    task automatic write_mode(input bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        url_sel = v;
        mode_writes++;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_len = pick_gap();
            out_stall <= (stall_len > 0);
            stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    // sampled mid-cycle: inputs only move on the rising edge, so this is the word
    // taken at the next edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word: out_char %h", out_char);
                errors++;
            end
            else
            begin
                got_want = pending_chars.pop_front();
                chars_checked++;
                if (out_char !== got_want.ch)
                begin
                    $error("out_char: expected %h, got %h", got_want.ch, out_char);
                    errors++;
                end
                if (run_last !== got_want.byte_end)
                begin
                    $error("run_last: expected %b, got %b", got_want.byte_end, run_last);
                    errors++;
                end
                if (message_end !== got_want.msg_end)
                begin
                    $error("message_end: expected %b, got %b", got_want.msg_end,
                           message_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("timed out with %0d characters outstanding", pending_chars.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int msg_len;
        bit [7:0] b;

        // standard alphabet after reset
        add_row(ROW_BYTE, 8'h00, 1'b1, 4, "AA==");
        add_row(ROW_BYTE, 8'hFF, 1'b1, 4, "/w==");
        add_row(ROW_BYTE, 8'h4D, 1'b0, 1, "T");
        add_row(ROW_BYTE, 8'h61, 1'b0, 1, "W");
        add_row(ROW_BYTE, 8'h6E, 1'b1, 2, "Fu");
        add_row(ROW_BYTE, 8'h00, 1'b0, 1, "A");
        add_row(ROW_BYTE, 8'h00, 1'b1, 3, "AA=");
        add_row(ROW_BYTE, 8'hFF, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'hFF, 1'b1, 0, 0);
        add_row(ROW_BYTE, 8'hFB, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'hFF, 1'b1, 0, 0);
        add_row(ROW_BYTE, 8'hAA, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'h55, 1'b1, 0, 0);
        // url alphabet, no padding
        add_row(ROW_MODE, 8'h01, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'h00, 1'b1, 2, "AA");
        add_row(ROW_BYTE, 8'hFF, 1'b1, 2, "_w");
        add_row(ROW_BYTE, 8'hFB, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'h80, 1'b0, 0, 0);
        // mode flips back while a message is open
        add_row(ROW_MODE, 8'h00, 1'b0, 0, 0);
        add_row(ROW_BYTE, 8'h01, 1'b1, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_MODE)
                write_mode(dir_rows[i].data[0]);
            else
                send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].n_typed,
                          dir_rows[i].typed_chars);
        end

        while (bytes_sent < dir_rows.size() + RANDOM_BYTES)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                write_mode(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 11) == 0)
                drain();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: msg_len = $urandom_range(1, 6);
                14, 15, 16, 17, 18: msg_len = $urandom_range(7, 16);
                default: msg_len = $urandom_range(17, 40);
            endcase
            for (int i = 0; i < msg_len; i++)
            begin
                if (i > 0 && $urandom_range(0, 49) == 0)
                    write_mode(1'($urandom_range(0, 1)));
                case ($urandom_range(0, 15))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, i == msg_len - 1, 0, 0);
            end
        end

        no_gaps = 1'b0;
        drain();
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d messages with %0d mode writes",
                 bytes_sent, msgs_sent, mode_writes);
        $display("checked %0d characters, %0d mismatches", chars_checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
